// File: src/dctq_pkg.sv
// Shared types, constants and helper functions for the 8x8 DCT quantizer.
`timescale 1ns / 1ps
package dctq_pkg;

  // Width of a working DCT value.
  localparam int unsigned WW = 24;
  typedef logic signed [WW-1:0] wval_t;

  localparam int unsigned CMD_PIXEL = 0;
  localparam int unsigned CMD_QUANT = 1;

  localparam logic signed [WW-1:0] DC_OFFSET = 24'sd8192;
  localparam logic [15:0] COEF_MAX_MAG = 16'd16384;

  // Datapath commands from the controller.
  typedef struct packed {
    logic       pix_wr;   // store incoming pixel
    logic       q_wr;     // store quantizer entry
    logic       ld;       // load one element into pass register
    logic [2:0] ld_k;     // element slot
    logic [5:0] addr;     // working store address
    logic       butterfly;// compute the 8-point pass
    logic       st;       // write one pass result back
    logic       div_start;// start a division
  } dctq_cmd_t;

  typedef struct packed {
    logic div_done;
  } dctq_sts_t;

  // Arithmetic shift right with floor rounding.
  function automatic wval_t asr(input wval_t x, input int unsigned s);
    asr = x >>> s;
  endfunction

endpackage

// File: src/dctq_ram.sv
// Generic single-port-write RAM with registered read.
`timescale 1ns / 1ps
module dctq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// File: src/dctq_datapath.sv
// Datapath: working store, 8-point pass unit, quantizer divider and output saturation.
`timescale 1ns / 1ps
module dctq_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dctq_pkg::dctq_cmd_t cmd_i,
  output dctq_pkg::dctq_sts_t sts_o,
  input  logic [7:0]          pixel_i,
  input  logic [5:0]          quant_index_i,
  input  logic [15:0]         quant_value_i,
  output logic signed [14:0]  coef_o
);
  import dctq_pkg::*;

  // Working store (holds pixels, then transformed values).
  logic        wr_en;
  logic [5:0]  wr_addr;
  wval_t       wr_data, rd_data;
  dctq_ram #(.WIDTH(WW), .DEPTH(64)) u_work (
    .clk_i, .we_i(wr_en), .waddr_i(wr_addr), .wdata_i(wr_data),
    .raddr_i(cmd_i.addr), .rdata_o(rd_data)
  );

  // Quantizer table, with valid bits giving the reset value one.
  logic [63:0] qv_q;
  logic [15:0] q_rd;
  dctq_ram #(.WIDTH(16), .DEPTH(64)) u_quant (
    .clk_i, .we_i(cmd_i.q_wr), .waddr_i(quant_index_i), .wdata_i(quant_value_i),
    .raddr_i(cmd_i.addr), .rdata_o(q_rd)
  );
  logic rd_valid_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qv_q <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (cmd_i.q_wr) qv_q[quant_index_i] <= 1'b1;
      rd_valid_q <= qv_q[cmd_i.addr];
    end
  end

  // Pass input and output registers.
  wval_t a_q [8];
  wval_t y_q [8];
  always_ff @(posedge clk_i) begin
    if (cmd_i.ld) a_q[cmd_i.ld_k] <= rd_data;
  end

  // One 8-point shift-and-add pass.
  wval_t y_d [8];
  always_comb begin
    wval_t s0, s1, s2, s3, d4, d5, d6, d7, e0, e1, e2, e3;
    wval_t p, q, r, t, o0, o1, o2, o3, m, n;
    s0 = a_q[0] + a_q[7]; d7 = a_q[0] - a_q[7];
    s1 = a_q[1] + a_q[6]; d6 = a_q[1] - a_q[6];
    s2 = a_q[2] + a_q[5]; d5 = a_q[2] - a_q[5];
    s3 = a_q[3] + a_q[4]; d4 = a_q[3] - a_q[4];
    e0 = s0 + s3; e3 = s0 - s3;
    e1 = s1 + s2; e2 = s1 - s2;
    y_d[0] = e0 + e1;
    y_d[4] = e0 - e1;
    p = e3 + e2; q = e3 - e2;
    r = p + asr(q, 1); t = q - asr(p, 1);
    y_d[2] = r - asr(t, 4);
    y_d[6] = t + asr(r, 4);
    p = d4 + asr(d7, 1); q = d7 - asr(d4, 1);
    r = p + asr(q, 3); t = q - asr(p, 3);
    r = r - asr(r, 3); t = t - asr(t, 3);
    o0 = r + asr(r, 6); o3 = t + asr(t, 6);
    p = d5 + asr(d6, 3); q = d6 - asr(d5, 3);
    o1 = p + asr(q, 4); o2 = q - asr(p, 4);
    m = o0 + o2; n = o3 + o1;
    y_d[5] = o0 - o2;
    y_d[3] = o3 - o1;
    y_d[1] = n + m;
    y_d[7] = n - m;
  end
  always_ff @(posedge clk_i) begin
    if (cmd_i.butterfly) y_q <= y_d;
  end

  // Working store write select: pixel or pass result.
  always_comb begin
    wr_en   = cmd_i.pix_wr | cmd_i.st;
    wr_addr = cmd_i.pix_wr ? cmd_i.addr : cmd_i.addr;
    wr_data = cmd_i.pix_wr ? wval_t'({16'd0, pixel_i}) : y_q[cmd_i.ld_k];
  end

  // Restoring divider: (2|c| + d) / (2d), one quotient bit per cycle.
  localparam int unsigned NB = 26;
  logic [NB-1:0] num_q, rem_q;
  logic [16:0]   den_q;
  logic [4:0]    cnt_q;
  logic          neg_q, busy_q, done_q;
  wval_t         c_in;
  logic [WW-1:0] mag;
  logic [15:0]   dv;
  logic [NB:0]   trial;
  always_comb begin
    c_in  = (cmd_i.addr == 6'd0) ? rd_data - DC_OFFSET : rd_data;
    mag   = c_in[WW-1] ? WW'(-c_in) : WW'(c_in);
    dv    = (!rd_valid_q) ? 16'd1 : ((q_rd == 16'd0) ? 16'd1 : q_rd);
    trial = {rem_q, num_q[NB-1]} - {10'd0, den_q};
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (cmd_i.div_start) begin
        busy_q <= 1'b1;
        cnt_q  <= 5'(NB - 1);
      end else if (busy_q) begin
        if (cnt_q == 5'd0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
        cnt_q <= cnt_q - 5'd1;
      end
    end
  end
  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      num_q <= NB'({mag, 1'b0}) + NB'(dv);
      rem_q <= '0;
      den_q <= {dv, 1'b0};
      neg_q <= c_in[WW-1];
    end else if (busy_q) begin
      if (!trial[NB]) begin
        rem_q <= trial[NB-1:0];
        num_q <= {num_q[NB-2:0], 1'b1};
      end else begin
        rem_q <= {rem_q[NB-2:0], num_q[NB-1]};
        num_q <= {num_q[NB-2:0], 1'b0};
      end
    end
  end

  // Saturate and apply sign.
  logic [15:0] qmag;
  always_comb begin
    qmag = (num_q > NB'(COEF_MAX_MAG)) ? COEF_MAX_MAG : num_q[15:0];
    if (neg_q) coef_o = 15'(-$signed({1'b0, qmag}));
    else       coef_o = (qmag > 16'd16383) ? 15'sd16383 : 15'(qmag);
  end

  assign sts_o.div_done = done_q;
endmodule

// File: src/dctq_ctrl.sv
// Controller: pixel counting, pass sequencing and result handshake.
`timescale 1ns / 1ps
module dctq_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                stall_o,
  input  logic                command_i,
  output dctq_pkg::dctq_cmd_t cmd_o,
  input  dctq_pkg::dctq_sts_t sts_i,
  output logic                valid_o,
  input  logic                stall_i,
  output logic [5:0]          coef_index_o,
  output logic                last_o
);
  import dctq_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LOAD = 3'd1;
  localparam logic [2:0] S_BFLY = 3'd2;
  localparam logic [2:0] S_STORE = 3'd3;
  localparam logic [2:0] S_QRD = 3'd4;
  localparam logic [2:0] S_DIV = 3'd5;
  localparam logic [2:0] S_OUT = 3'd6;

  logic [2:0] state_q, state_d;
  logic [5:0] pcnt_q, pcnt_d;
  logic [3:0] k_q, k_d;     // element step, one extra for read latency
  logic [3:0] line_q, line_d; // bit 3 selects column passes
  logic [5:0] oidx_q, oidx_d;
  logic       ostart_q, ostart_d;

  logic acc;
  assign stall_o = (state_q != S_IDLE);
  assign acc = valid_i & ~stall_o;

  // Address of element kk of the current line.
  function automatic logic [5:0] eaddr(input logic [3:0] ln, input logic [2:0] kk);
    eaddr = ln[3] ? {kk, ln[2:0]} : {ln[2:0], kk};
  endfunction

  always_comb begin
    state_d = state_q; pcnt_d = pcnt_q; k_d = k_q; line_d = line_q;
    oidx_d = oidx_q; ostart_d = 1'b0;
    cmd_o = '0;
    cmd_o.addr = pcnt_q;
    valid_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (acc && command_i == 1'(CMD_QUANT)) cmd_o.q_wr = 1'b1;
        if (acc && command_i == 1'(CMD_PIXEL)) begin
          cmd_o.pix_wr = 1'b1;
          pcnt_d = pcnt_q + 6'd1;
          if (pcnt_q == 6'd63) begin
            state_d = S_LOAD; k_d = '0; line_d = '0;
          end
        end
      end
      S_LOAD: begin
        // Read address is presented in the cycle before its element is loaded.
        cmd_o.addr = eaddr(line_q, k_q[2:0]);
        if (k_q != 4'd0) begin
          cmd_o.ld = 1'b1;
          cmd_o.ld_k = 3'(k_q - 4'd1);
        end
        k_d = k_q + 4'd1;
        if (k_q == 4'd8) state_d = S_BFLY;
      end
      S_BFLY: begin
        cmd_o.butterfly = 1'b1;
        k_d = '0; state_d = S_STORE;
      end
      S_STORE: begin
        cmd_o.st = 1'b1;
        cmd_o.ld_k = k_q[2:0];
        cmd_o.addr = eaddr(line_q, k_q[2:0]);
        k_d = k_q + 4'd1;
        if (k_q == 4'd7) begin
          k_d = '0;
          line_d = line_q + 4'd1;
          if (line_q == 4'd15) begin
            state_d = S_QRD; oidx_d = '0;
          end else state_d = S_LOAD;
        end
      end
      S_QRD: begin
        // Registered read of coefficient and quantizer entry.
        cmd_o.addr = oidx_q;
        ostart_d = ostart_q ? 1'b0 : 1'b1;
        if (ostart_q) begin
          cmd_o.div_start = 1'b1;
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        if (sts_i.div_done) state_d = S_OUT;
      end
      S_OUT: begin
        valid_o = 1'b1;
        if (!stall_i) begin
          oidx_d = oidx_q + 6'd1;
          state_d = (oidx_q == 6'd63) ? S_IDLE : S_QRD;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign coef_index_o = oidx_q;
  assign last_o = (oidx_q == 6'd63);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; pcnt_q <= '0; k_q <= '0; line_q <= '0;
      oidx_q <= '0; ostart_q <= 1'b0;
    end else begin
      state_q <= state_d; pcnt_q <= pcnt_d; k_q <= k_d; line_q <= line_d;
      oidx_q <= oidx_d; ostart_q <= ostart_d;
    end
  end
endmodule

// File: src/dct8x8_quantizer_top.sv
// Top level of the 8x8 DCT quantizer.
// Sequence: the 64th pixel starts 16 passes (load, butterfly, store), then every item of
// output is read, divided by the 26-step divider and presented before the next is read.
// Throughput: one pixel or quantizer write per cycle while collecting; the divider
// and the single-write-port working store set the block time.
// Reset clears the pixel count, the controller and the quantizer table to one.
`timescale 1ns / 1ps
module dct8x8_quantizer_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               stall_o,
  input  logic               command_i,
  input  logic [7:0]         pixel_i,
  input  logic [5:0]         quant_index_i,
  input  logic [15:0]        quant_value_i,
  output logic               valid_o,
  input  logic               stall_i,
  output logic signed [14:0] coefficient_o,
  output logic [5:0]         coef_index_o,
  output logic               last_o
);
  import dctq_pkg::*;

  dctq_cmd_t cmd;
  dctq_sts_t sts;

  dctq_ctrl u_ctrl (
    .clk_i, .rst_ni, .valid_i, .stall_o, .command_i, .cmd_o(cmd), .sts_i(sts),
    .valid_o, .stall_i, .coef_index_o, .last_o
  );

  dctq_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts), .pixel_i, .quant_index_i,
    .quant_value_i, .coef_o(coefficient_o)
  );
endmodule

// File: src/dctq_checker.sv
// Port-level checker for the 8x8 DCT quantizer, bound to the top level.
`timescale 1ns / 1ps
module dctq_sva (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        stall_o,
  input logic        valid_o,
  input logic        stall_i,
  input logic [5:0]  coef_index_o,
  input logic        last_o
);
  // Last flag marks exactly the final index.
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (last_o == (coef_index_o == 6'd63))) else $error("last flag wrong");

  // Results advance index by one after each accepted item.
  a_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !stall_i && !last_o) |=> (coef_index_o == $past(coef_index_o) + 6'd1))
    else $error("index skip");

  // No input is taken while results are shown.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> stall_o) else $error("input open during output");

  // Stalled result holds.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && stall_i) |=> (valid_o && $stable(coef_index_o))) else $error("drop");
endmodule

bind dct8x8_quantizer_top dctq_sva u_chk (
  .clk_i, .rst_ni, .stall_o, .valid_o, .stall_i, .coef_index_o, .last_o
);

// File: test/dctq_checker.sv
// Checker for the 8x8 DCT quantizer: predicts coefficients and compares them.
`timescale 1ns / 1ps
module dctq_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  logic               stall_o,
  input  logic               command_i,
  input  logic [7:0]         pixel_i,
  input  logic [5:0]         quant_index_i,
  input  logic [15:0]        quant_value_i,
  input  logic               valid_o,
  input  logic               stall_i,
  input  logic signed [14:0] coefficient_o,
  input  logic [5:0]         coef_index_o,
  input  logic               last_o,
  output int                 errors_o,
  output int                 pending_o,
  output int                 blocks_o,
  output int                 qwrites_o
);
  import dctq_pkg::*;

  typedef struct {
    logic signed [14:0] coef;
    logic [5:0]         idx;
    logic               last;
  } coef_t;

  coef_t       coef_q[$];
  int          pix_store[64];
  logic [15:0] qtab[64];
  int          pcount;
  int          wk[64];

  function automatic int sra(input int x, input int s);
    return x >>> s;
  endfunction

  // One 8-point shift-and-add transform along a row or a column of wk.
  function automatic void dct_pass(input int base, input int stride);
    int a[8];
    int s0, s1, s2, s3, d4, d5, d6, d7, e0, e1, e2, e3;
    int p, q, r, t, o0, o1, o2, o3, m, n;
    for (int i = 0; i < 8; i++) a[i] = wk[(base + i * stride) & 63];
    s0 = a[0] + a[7]; d7 = a[0] - a[7];
    s1 = a[1] + a[6]; d6 = a[1] - a[6];
    s2 = a[2] + a[5]; d5 = a[2] - a[5];
    s3 = a[3] + a[4]; d4 = a[3] - a[4];
    e0 = s0 + s3; e3 = s0 - s3;
    e1 = s1 + s2; e2 = s1 - s2;
    wk[base] = e0 + e1;
    wk[(base + 4 * stride) & 63] = e0 - e1;
    p = e3 + e2; q = e3 - e2;
    r = p + sra(q, 1); t = q - sra(p, 1);
    wk[(base + 2 * stride) & 63] = r - sra(t, 4);
    wk[(base + 6 * stride) & 63] = t + sra(r, 4);
    // Odd part: rotations approximated by shifts.
    p = d4 + sra(d7, 1); q = d7 - sra(d4, 1);
    r = p + sra(q, 3); t = q - sra(p, 3);
    r = r - sra(r, 3); t = t - sra(t, 3);
    o0 = r + sra(r, 6); o3 = t + sra(t, 6);
    p = d5 + sra(d6, 3); q = d6 - sra(d5, 3);
    o1 = p + sra(q, 4); o2 = q - sra(p, 4);
    m = o0 + o2; n = o3 + o1;
    wk[(base + 5 * stride) & 63] = o0 - o2;
    wk[(base + 3 * stride) & 63] = o3 - o1;
    wk[(base + 1 * stride) & 63] = n + m;
    wk[(base + 7 * stride) & 63] = n - m;
  endfunction

  // Divide with rounding half away from zero, then saturate.
  function automatic logic signed [14:0] quantize(input int c, input logic [15:0] dv);
    longint d, mag, qv, r;
    d   = (dv == 0) ? 1 : dv;
    mag = (c < 0) ? -c : c;
    qv  = (2 * mag + d) / (2 * d);
    if (qv > 16384) qv = 16384;
    r = (c < 0) ? -qv : qv;
    if (r > 16383) r = 16383;
    if (r < -16384) r = -16384;
    return r[14:0];
  endfunction

  task automatic report(input string what, input int got, input int want);
    $display("%0t ns: mismatch in %s: got %0d, expected %0d", $time, what, got, want);
    errors_o++;
  endtask

  assign pending_o = coef_q.size();

  // Track accepted items and build expectations on each full block.
  always @(posedge clk_i or negedge rst_ni) begin
    coef_t e;
    if (!rst_ni) begin
      pcount = 0;
      for (int i = 0; i < 64; i++) begin
        qtab[i] = 16'd1;
        pix_store[i] = 0;
      end
    end else begin
      if (valid_i && !stall_o) begin
        if (command_i == CMD_QUANT[0]) begin
          qtab[quant_index_i] = quant_value_i;
          qwrites_o++;
        end else begin
          pix_store[pcount] = pixel_i;
          pcount = (pcount + 1) & 63;
          if (pcount == 0) begin
            wk = pix_store;
            for (int i = 0; i < 8; i++) dct_pass(i * 8, 1);
            for (int i = 0; i < 8; i++) dct_pass(i, 8);
            wk[0] -= 8192;
            for (int i = 0; i < 64; i++) begin
              e.coef = quantize(wk[i], qtab[i]);
              e.idx  = 6'(i);
              e.last = (i == 63);
              coef_q.push_back(e);
            end
            blocks_o++;
          end
        end
      end
      // Compare each accepted coefficient with the oldest expectation.
      if (valid_o && !stall_i) begin
        if (coef_q.size() == 0) begin
          report("unexpected coefficient index", coef_index_o, -1);
        end else begin
          e = coef_q.pop_front();
          if (coefficient_o !== e.coef) report("coefficient", coefficient_o, e.coef);
          if (coef_index_o !== e.idx) report("coef_index", coef_index_o, e.idx);
          if (last_o !== e.last) report("last", last_o, e.last);
        end
      end
    end
  end

  initial begin
    errors_o = 0;
    blocks_o = 0;
    qwrites_o = 0;
  end
endmodule

// File: test/tb_dct8x8_quantizer_top.sv
// Testbench top for the 8x8 DCT quantizer: stimulus, idling and verdict.
`timescale 1ns / 1ps
module tb_dct8x8_quantizer_top;
  import dctq_pkg::*;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               valid_i = 1'b0;
  logic               stall_o;
  logic               command_i = 1'b0;
  logic [7:0]         pixel_i = '0;
  logic [5:0]         quant_index_i = '0;
  logic [15:0]        quant_value_i = '0;
  logic               valid_o;
  logic               stall_i = 1'b0;
  logic signed [14:0] coefficient_o;
  logic [5:0]         coef_index_o;
  logic               last_o;
  int                 errors, pending, blocks, qwrites;
  int                 idle_pct = 0;
  int                 stall_pct = 0;
  int                 sent = 0;

  dct8x8_quantizer_top dut (.*);

  dctq_checker chk (
    .clk_i, .rst_ni, .valid_i, .stall_o, .command_i, .pixel_i, .quant_index_i,
    .quant_value_i, .valid_o, .stall_i, .coefficient_o, .coef_index_o, .last_o,
    .errors_o(errors), .pending_o(pending), .blocks_o(blocks), .qwrites_o(qwrites)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Receiver stalls at random according to the current phase.
  always @(negedge clk_i) begin
    stall_i <= ($urandom_range(99) < stall_pct);
  end

  // Send one item, with random idle cycles ahead of it. Called at a falling
  // edge; returns at the falling edge after the item was accepted, with valid
  // still high so that the next item can follow without a gap.
  task automatic send(input logic cmd, input logic [7:0] pix, input logic [5:0] qi,
                      input logic [15:0] qv);
    while ($urandom_range(99) < idle_pct) begin
      valid_i <= 1'b0;
      @(negedge clk_i);
    end
    valid_i       <= 1'b1;
    command_i     <= cmd;
    pixel_i       <= pix;
    quant_index_i <= qi;
    quant_value_i <= qv;
    @(posedge clk_i);
    while (stall_o) @(posedge clk_i);
    sent++;
    @(negedge clk_i);
  endtask

  task automatic send_pixel(input logic [7:0] pix);
    send(CMD_PIXEL[0], pix, 6'($urandom_range(63)), 16'($urandom_range(65535)));
  endtask

  task automatic send_quant(input logic [5:0] qi, input logic [15:0] qv);
    send(CMD_QUANT[0], 8'($urandom_range(255)), qi, qv);
  endtask

  // Drop valid and wait until every expected coefficient has come out.
  task automatic wait_drain();
    valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  initial begin
    int phase;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: quantizer extremes, including a zero divisor.
    send_quant(6'd0, 16'd0);
    send_quant(6'd63, 16'd65535);
    send_quant(6'd1, 16'd1);
    send_quant(6'd9, 16'd3);
    send_quant(6'd2, 16'hAAAA);
    send_quant(6'd3, 16'h5555);
    // All-white block with no idling.
    for (int i = 0; i < 64; i++) send_pixel(8'd255);
    // Checkerboard that drives large AC terms, with sender gaps.
    idle_pct = 57; stall_pct = 0;
    for (int i = 0; i < 64; i++) send_pixel(((i >> 3) ^ i) & 1 ? 8'd255 : 8'd0);
    // Let the sender pause until every coefficient has come out.
    wait_drain();
    // All-black block with a rounding-friendly divisor at DC, receiver stalling.
    idle_pct = 0; stall_pct = 57;
    send_quant(6'd0, 16'd2);
    for (int i = 0; i < 64; i++) send_pixel(8'd0);

    // Random blocks; idling phase changes every block.
    phase = 3;
    while (sent < 280 || chk.pcount != 0) begin
      if (chk.pcount == 0) begin
        case (phase % 4)
          0: begin idle_pct = 0;  stall_pct = 0;  end
          1: begin idle_pct = 57; stall_pct = 0;  end
          2: begin idle_pct = 0;  stall_pct = 57; end
          default: begin idle_pct = 34; stall_pct = 34; end
        endcase
        phase++;
      end
      if ($urandom_range(9) == 0)
        send_quant(6'($urandom_range(63)), $urandom_range(3) == 0 ?
                   16'($urandom_range(65535)) : 16'($urandom_range(1, 64)));
      else
        send_pixel(8'($urandom_range(255)));
    end

    wait_drain();
    repeat (200) @(posedge clk_i);
    $display("Sent %0d items: %0d full blocks and %0d quantizer writes,", sent, blocks,
             qwrites);
    $display("across idle, sender-gap, receiver-stall and mixed phases.");
    if (errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Overall time limit.
  initial begin
    #8ms;
    $display("Timeout with %0d coefficients still expected", pending);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
